/* design/assert_macros.svh */
// assertion macros used by the checker file
// every macro samples on i_clk and is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge out of reset
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication from a trigger to a consequent on the next edge
`define CHK_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* design/clc_pkg.sv */
// shared types and constants for the card number luhn classifier
// used by the digit cell, the luhn accumulator and the top level
`default_nettype none

package clc_pkg;

    localparam int unsigned IN_W    = 63;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COUNT_W = 5;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_AMEX    = 2'd1;
    localparam logic [1:0] VERDICT_MASTER  = 2'd2;
    localparam logic [1:0] VERDICT_VISA    = 2'd3;

    // control shared by every cell of the digit row
    typedef struct packed {
        logic clear;
        logic shift;
        logic scan;
    } t_cell_ctl;

    // control of the luhn accumulator
    typedef struct packed {
        logic clear;
        logic step;
    } t_acc_ctl;

    // what the accumulator has gathered once the row is scanned
    typedef struct packed {
        logic [DIGIT_W-1:0] sum_mod;
        logic [COUNT_W-1:0] count;
        logic [DIGIT_W-1:0] top_hi;
        logic [DIGIT_W-1:0] top_lo;
    } t_acc_res;

endpackage

`default_nettype wire

/* design/card_number_luhn_classifier.sv */
// card number luhn classifier: bit-serial binary to decimal row, then a digit scan
// one item at a time: its bits are shifted through the digit row, its digits are
// scanned into the luhn accumulator, and the verdict is formed once the output
// register is free; the result sits in that output register until taken, while
// a new item may be accepted
// reset (synchronous, active low) returns the sequencer to idle and drops o_out_valid
`default_nettype none

module card_number_luhn_classifier #(
    parameter int unsigned MAX_DIGITS = 19
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [clc_pkg::IN_W-1:0]    i_card_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_verdict,
    output logic                             o_luhn_pass,
    output logic [clc_pkg::COUNT_W-1:0]      o_digit_count
);

    localparam int unsigned CNT_W = $clog2(clc_pkg::IN_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [CNT_W-1:0]             r_cnt;
    logic [CNT_W-1:0]             n_cnt;
    logic [clc_pkg::IN_W-1:0]     r_bin;
    logic                         r_ovf;
    logic                         r_out_valid;
    logic [1:0]                   r_verdict;
    logic                         r_pass;
    logic [clc_pkg::COUNT_W-1:0]  r_count;

    clc_pkg::t_cell_ctl           cell_ctl;
    clc_pkg::t_acc_ctl            acc_ctl;
    clc_pkg::t_acc_res            acc_res;

    logic [MAX_DIGITS:0]          carry;
    logic [clc_pkg::DIGIT_W-1:0]  digit [MAX_DIGITS+1];

    logic                         accept;
    logic                         out_free;
    logic                         fin_load;
    logic                         pass;
    logic [1:0]                   verdict;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign fin_load = (r_state == ST_FIN) && out_free;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        cell_ctl = '{clear: accept, shift: (r_state == ST_CONV), scan: (r_state == ST_SCAN)};
        acc_ctl  = '{clear: accept, step: (r_state == ST_SCAN)};
    end

    // row of digit cells: carries run upward, scanned digits run downward
    assign carry[0]          = r_bin[clc_pkg::IN_W-1];
    assign digit[MAX_DIGITS] = '0;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        clc_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_carry (carry[g]),
            .i_digit (digit[g+1]),
            .o_carry (carry[g+1]),
            .o_digit (digit[g])
        );
    end

    clc_luhn_acc u_acc (
        .i_clk   (i_clk),
        .i_ctl   (acc_ctl),
        .i_pos   (r_cnt[clc_pkg::COUNT_W-1:0]),
        .i_digit (digit[0]),
        .o_res   (acc_res)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CONV;
                    n_cnt   = '0;
                end
            end
            ST_CONV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(clc_pkg::IN_W - 1)) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAX_DIGITS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // brand match on the gathered leading digits
    always_comb begin
        pass    = (acc_res.sum_mod == '0) && !r_ovf;
        verdict = clc_pkg::VERDICT_INVALID;
        if (pass) begin
            if (acc_res.count == 5'd15 && acc_res.top_hi == 4'd3
                    && (acc_res.top_lo == 4'd4 || acc_res.top_lo == 4'd7)) begin
                verdict = clc_pkg::VERDICT_AMEX;
            end else if (acc_res.count == 5'd16 && acc_res.top_hi == 4'd5
                    && acc_res.top_lo >= 4'd1 && acc_res.top_lo <= 4'd5) begin
                verdict = clc_pkg::VERDICT_MASTER;
            end else if ((acc_res.count == 5'd16 || acc_res.count == 5'd13)
                    && acc_res.top_hi == 4'd4) begin
                verdict = clc_pkg::VERDICT_VISA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin <= i_card_value;
            r_ovf <= 1'b0;
        end else if (r_state == ST_CONV) begin
            r_bin <= {r_bin[clc_pkg::IN_W-2:0], 1'b0};
            // a bit shifted out of the top digit means too many digits
            if (carry[MAX_DIGITS]) begin
                r_ovf <= 1'b1;
            end
        end
        if (fin_load) begin
            r_verdict <= verdict;
            r_pass    <= pass;
            r_count   <= r_ovf ? clc_pkg::COUNT_W'(MAX_DIGITS) : acc_res.count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_luhn_pass   = r_pass;
    assign o_digit_count = r_count;

endmodule

`default_nettype wire

/* design/clc_digit_cell.sv */
// one decimal digit of the shift-and-add-3 converter row
// depends on clc_pkg for the control struct and digit width
`default_nettype none

module clc_digit_cell (
    input  wire logic                        i_clk,
    input  wire clc_pkg::t_cell_ctl          i_ctl,
    input  wire logic                        i_carry,
    input  wire logic [clc_pkg::DIGIT_W-1:0] i_digit,
    output logic                             o_carry,
    output logic [clc_pkg::DIGIT_W-1:0]      o_digit
);

    logic [clc_pkg::DIGIT_W-1:0] r_digit;
    logic [clc_pkg::DIGIT_W-1:0] n_digit;
    logic [clc_pkg::DIGIT_W-1:0] adj;

    // correct before the shift so the doubled digit stays decimal
    assign adj     = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = adj[clc_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift) begin
            n_digit = {adj[clc_pkg::DIGIT_W-2:0], i_carry};
        end else if (i_ctl.scan) begin
            // digits move toward the low end, one per cycle
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

/* design/clc_luhn_acc.sv */
// luhn sum, digit count and leading digits, one digit per cycle while stepped
// depends on clc_pkg for control and result structs
`default_nettype none

module clc_luhn_acc (
    input  wire logic                        i_clk,
    input  wire clc_pkg::t_acc_ctl           i_ctl,
    input  wire logic [clc_pkg::COUNT_W-1:0] i_pos,
    input  wire logic [clc_pkg::DIGIT_W-1:0] i_digit,
    output clc_pkg::t_acc_res                o_res
);

    logic [clc_pkg::DIGIT_W-1:0] r_sum;
    logic [clc_pkg::COUNT_W-1:0] r_count;
    logic [clc_pkg::DIGIT_W-1:0] r_top_hi;
    logic [clc_pkg::DIGIT_W-1:0] r_top_lo;
    logic [clc_pkg::DIGIT_W-1:0] r_prev;

    logic [clc_pkg::DIGIT_W:0]   dbl;
    logic [clc_pkg::DIGIT_W-1:0] term;
    logic [clc_pkg::DIGIT_W:0]   tot;

    always_comb begin
        dbl  = {i_digit, 1'b0};
        term = i_digit;
        if (i_pos[0]) begin
            // doubled digit above nine folds to its digit sum
            term = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[clc_pkg::DIGIT_W-1:0];
        end
        tot = {1'b0, r_sum} + {1'b0, term};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_top_hi <= '0;
            r_top_lo <= '0;
            r_prev   <= '0;
        end else if (i_ctl.step) begin
            r_sum  <= (tot >= 5'd10) ? 4'(tot - 5'd10) : tot[clc_pkg::DIGIT_W-1:0];
            r_prev <= i_digit;
            if (i_digit != '0) begin
                r_count  <= i_pos + 5'd1;
                r_top_hi <= i_digit;
                r_top_lo <= r_prev;
            end
        end
    end

    assign o_res = '{sum_mod: r_sum, count: r_count, top_hi: r_top_hi, top_lo: r_top_lo};

endmodule

`default_nettype wire

/* design/clc_checker.sv */
// port-level checks for the card number luhn classifier, bound to the top level
// depends on assert_macros.svh and clc_pkg
`default_nettype none
`include "assert_macros.svh"

module clc_checker #(
    parameter int unsigned MAX_DIGITS = 19
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        o_in_ready,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [1:0]                  o_verdict,
    input  wire logic                        o_luhn_pass,
    input  wire logic [clc_pkg::COUNT_W-1:0] o_digit_count
);

    // an unaccepted result holds still
    `CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_verdict) && $stable(o_luhn_pass)
        && $stable(o_digit_count), "result changed while stalled")

    // one item at a time: busy right after an accept
    `CHK_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "input ready right after an accept")

    `CHK_ALWAYS(a_brand_needs_pass,
        !o_out_valid || o_verdict == clc_pkg::VERDICT_INVALID || o_luhn_pass,
        "brand given without luhn pass")

    `CHK_ALWAYS(a_amex_len,
        !o_out_valid || o_verdict != clc_pkg::VERDICT_AMEX || o_digit_count == 5'd15,
        "amex with wrong digit count")

    `CHK_ALWAYS(a_count_range,
        !o_out_valid || o_digit_count <= clc_pkg::COUNT_W'(MAX_DIGITS),
        "digit count beyond the row")

endmodule

bind card_number_luhn_classifier clc_checker #(.MAX_DIGITS(MAX_DIGITS)) u_clc_checker (.*);

`default_nettype wire

/* test/tb.sv */
// self-checking testbench for card_number_luhn_classifier
// predicts verdict, luhn flag and digit count per card; needs clc_pkg and the rtl only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned     CARD_MAX_DIGITS = 19;
    localparam longint unsigned CARD_MASK       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int unsigned     N_RANDOM        = 1030;
    localparam int unsigned     DRAIN_CYCLES    = 100;

    typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct {
        logic [clc_pkg::IN_W-1:0]    card;
        logic [1:0]                  verdict;
        logic                        luhn_ok;
        logic [clc_pkg::COUNT_W-1:0] digits;
    } t_card_check;

    class luhn_scoreboard;
        t_card_check awaiting[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned luhn_ok_seen;
        int unsigned verdict_seen[4];

        function t_card_check classify_card(logic [clc_pkg::IN_W-1:0] card);
            t_card_check     res;
            longint unsigned rest;
            int unsigned     sum;
            int unsigned     n;
            int unsigned     d;
            int unsigned     top1;
            int unsigned     prev;
            int unsigned     top2;
            rest        = 64'(card);
            sum         = 0;
            n           = 0;
            top1        = 0;
            prev        = 0;
            res.card    = card;
            res.verdict = clc_pkg::VERDICT_INVALID;
            // least significant digit first, odd positions doubled
            while (rest != 0 && n < CARD_MAX_DIGITS) begin
                d    = 32'(rest % 10);
                rest = rest / 10;
                prev = top1;
                top1 = d;
                if (n % 2 == 1) begin
                    d = 2 * d;
                    if (d > 9) begin
                        d = d - 9;
                    end
                end
                sum += d;
                n++;
            end
            if (rest != 0) begin
                res.luhn_ok = 1'b0;
                res.digits  = clc_pkg::COUNT_W'(CARD_MAX_DIGITS);
                return res;
            end
            res.luhn_ok = (sum % 10 == 0);
            res.digits  = clc_pkg::COUNT_W'(n);
            top2        = (n >= 2) ? top1 * 10 + prev : 0;
            if (res.luhn_ok) begin
                if (n == 15 && (top2 == 34 || top2 == 37)) begin
                    res.verdict = clc_pkg::VERDICT_AMEX;
                end else if (n == 16 && top2 >= 51 && top2 <= 55) begin
                    res.verdict = clc_pkg::VERDICT_MASTER;
                end else if (n == 16 && top1 == 4) begin
                    res.verdict = clc_pkg::VERDICT_VISA;
                end else if (n == 13 && top1 == 4) begin
                    res.verdict = clc_pkg::VERDICT_VISA;
                end
            end
            return res;
        endfunction

        function void note_card(logic [clc_pkg::IN_W-1:0] card);
            awaiting.push_back(classify_card(card));
        endfunction

        function void check_result(logic [1:0] verdict, logic luhn_ok,
                                   logic [clc_pkg::COUNT_W-1:0] digits);
            t_card_check want;
            if (awaiting.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: verdict %0d luhn %0d digits %0d",
                             verdict, luhn_ok, digits);
                end
                return;
            end
            want = awaiting.pop_front();
            results_seen++;
            luhn_ok_seen += 32'(want.luhn_ok);
            verdict_seen[want.verdict]++;
            if (verdict !== want.verdict || luhn_ok !== want.luhn_ok
                    || digits !== want.digits) begin
                errors++;
                if (errors <= 10) begin
                    $display("card %0d: expected verdict %0d luhn %0d digits %0d, got %0d %0d %0d",
                             want.card, want.verdict, want.luhn_ok, want.digits,
                             verdict, luhn_ok, digits);
                end
            end
        endfunction

        function int unsigned pending();
            return awaiting.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [clc_pkg::IN_W-1:0]    i_card_value = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [1:0]                  o_verdict;
    logic                        o_luhn_pass;
    logic [clc_pkg::COUNT_W-1:0] o_digit_count;

    luhn_scoreboard sb = new();

    t_rx_mode    rx_mode = RX_ALWAYS;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;

    card_number_luhn_classifier #(
        .MAX_DIGITS(CARD_MAX_DIGITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_card_value (i_card_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .o_luhn_pass  (o_luhn_pass),
        .o_digit_count(o_digit_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned pow10(int unsigned k);
        longint unsigned p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    function automatic longint unsigned rand_below(longint unsigned m);
        longint unsigned r;
        r = {$urandom, $urandom};
        return r % m;
    endfunction

    function automatic int unsigned luhn_total(longint unsigned v);
        int unsigned s;
        int unsigned pos;
        int unsigned d;
        s   = 0;
        pos = 0;
        while (v != 0) begin
            d = 32'(v % 10);
            v = v / 10;
            if (pos % 2 == 1) begin
                d = (2 * d > 9) ? 2 * d - 9 : 2 * d;
            end
            s += d;
            pos++;
        end
        return s;
    endfunction

    // appends the digit that makes the luhn sum a multiple of ten
    function automatic longint unsigned with_check_digit(longint unsigned body);
        int unsigned s;
        s = luhn_total(body * 10);
        return body * 10 + 64'((10 - s % 10) % 10);
    endfunction

    // changes the last digit without a carry, so the luhn sum fails
    function automatic longint unsigned break_check(longint unsigned v);
        return (v % 10 == 9) ? v - 9 : v + 1;
    endfunction

    function automatic longint unsigned random_card();
        int unsigned     kind;
        int unsigned     n;
        int unsigned     lead;
        longint unsigned v;
        kind = $urandom_range(0, 11);
        n    = $urandom_range(1, CARD_MAX_DIGITS);
        // a 19 digit value must stay below 2^63
        lead = $urandom_range(1, (n == CARD_MAX_DIGITS) ? 8 : 9);
        case (kind) inside
            0, 1: begin
                v = ($urandom_range(0, 1) ? 34 : 37) * pow10(12) + rand_below(pow10(12));
                v = with_check_digit(v);
            end
            2, 3: begin
                v = with_check_digit($urandom_range(50, 56) * pow10(13)
                                     + rand_below(pow10(13)));
            end
            4, 5: v = with_check_digit(4 * pow10(14) + rand_below(pow10(14)));
            6:    v = with_check_digit(4 * pow10(11) + rand_below(pow10(11)));
            7: begin
                if (n == 1) begin
                    v = 64'(lead);
                end else begin
                    v = with_check_digit(lead * pow10(n - 2) + rand_below(pow10(n - 2)));
                end
            end
            8:     v = lead * pow10(n - 1) + rand_below(pow10(n - 1));
            9, 10: v = {$urandom, $urandom};
            default: v = 64'($urandom_range(0, 9999));
        endcase
        if (kind <= 7 && $urandom_range(0, 4) == 0) begin
            v = break_check(v);
        end
        return v & CARD_MASK;
    endfunction

    task automatic send_card(longint unsigned v);
        i_in_valid   <= 1'b1;
        i_card_value <= v[clc_pkg::IN_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold the sender until every card in flight has its result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS: i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            default:   i_out_ready <= (rx_tick % 16 < 11);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_card(i_card_value);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_verdict, o_luhn_pass, o_digit_count);
        end
    end

    initial begin
        longint unsigned directed[$];
        int unsigned     k;
        int unsigned     burst_left;
        directed = '{
            64'd0, 64'd1, 64'd18, CARD_MASK, pow10(18), pow10(18) - 1,
            with_check_digit(34 * pow10(12) + 64'd123456789012),
            with_check_digit(37 * pow10(12)),
            with_check_digit(35 * pow10(12) + 5),
            with_check_digit(34 * pow10(13) + 7),
            with_check_digit(51 * pow10(13) + 64'd9876543210),
            with_check_digit(55 * pow10(13) + 64'd9999999999999),
            with_check_digit(50 * pow10(13) + 3),
            with_check_digit(56 * pow10(13) + 3),
            with_check_digit(4 * pow10(14) + 64'd11112222333),
            with_check_digit(4 * pow10(11) + 64'd22222222222),
            with_check_digit(4 * pow10(12) + 1),
            with_check_digit(4 * pow10(17)),
            break_check(with_check_digit(4 * pow10(14) + 64'd55555)),
            break_check(with_check_digit(37 * pow10(12) + 64'd424242)),
            break_check(with_check_digit(4 * pow10(11) + 64'd9)),
            with_check_digit(3 * pow10(14)),
            64'd4,
            64'h5555_5555_5555_5555 & CARD_MASK
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cards back to back
        foreach (directed[i]) begin
            send_card(directed[i]);
        end
        wait_drained();

        burst_left = $urandom_range(1, 20);
        for (k = 0; k < N_RANDOM; k++) begin
            send_card(random_card());
            if (k == N_RANDOM / 2) begin
                wait_drained();
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 100)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 20);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.pending();

        $display("checked %0d cards: amex %0d, mastercard %0d, visa %0d, invalid %0d",
                 sb.results_seen, sb.verdict_seen[clc_pkg::VERDICT_AMEX],
                 sb.verdict_seen[clc_pkg::VERDICT_MASTER],
                 sb.verdict_seen[clc_pkg::VERDICT_VISA],
                 sb.verdict_seen[clc_pkg::VERDICT_INVALID]);
        $display("%0d passed the luhn sum, %0d mismatches", sb.luhn_ok_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d cards outstanding", sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
